/* sv/dtcv_pkg.sv */
// dtcv_pkg: types and constants for the decimal text to centi value unit
// no dependencies; imported by decimal_text_to_centi_value_unit and tb_top
package dtcv_pkg;

    // text bytes of interest
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_POINT = 8'h2e;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // whole part saturation bound
    localparam logic [8:0] WHOLE_MAX = 9'd511;

    // magnitude limits in hundredths
    localparam logic [15:0] MAG_MAX_POS = 16'd32767;
    localparam logic [15:0] MAG_MAX_NEG = 16'd32768;

    // configuration register indexes
    localparam logic [1:0] CFG_MIN_CONFIDENCE = 2'd0;
    localparam logic [1:0] CFG_PLAUSIBLE_MIN  = 2'd1;
    localparam logic [1:0] CFG_PLAUSIBLE_MAX  = 2'd2;

    // configuration reset values
    localparam logic [6:0]         MIN_CONF_RESET = 7'd60;
    localparam logic signed [15:0] PMIN_RESET     = -16'sd4000;
    localparam logic signed [15:0] PMAX_RESET     = 16'sd12500;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_RECOG     = 2'd1,
        STATUS_LOW_CONF  = 2'd2,
        STATUS_RANGE     = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        REASON_NONE        = 4'd0,
        REASON_EMPTY       = 4'd1,
        REASON_LOW_CONF    = 4'd2,
        REASON_DUP_POINT   = 4'd3,
        REASON_BAD_CHAR    = 4'd4,
        REASON_TOO_MANY    = 4'd5,
        REASON_NO_DIGITS   = 4'd6,
        REASON_OVERFLOW    = 4'd7,
        REASON_IMPLAUSIBLE = 4'd8
    } reason_t;

    // running parse state of one text
    typedef struct packed {
        logic       at_start;
        logic       negative;
        logic [8:0] whole_part;
        logic       whole_overflow;
        logic [6:0] fraction_part;
        logic [1:0] fraction_digits;
        logic       digit_found;
        logic       seen_point;
        reason_t    latched_error;
    } parse_t;

    localparam parse_t PARSE_CLEAR = '{
        at_start:        1'b1,
        negative:        1'b0,
        whole_part:      9'd0,
        whole_overflow:  1'b0,
        fraction_part:   7'd0,
        fraction_digits: 2'd0,
        digit_found:     1'b0,
        seen_point:      1'b0,
        latched_error:   REASON_NONE
    };

endpackage

/* sv/decimal_text_to_centi_value_unit.sv */
// decimal_text_to_centi_value_unit: parses reading text into a signed value in hundredths
// depends on dtcv_pkg
//
//  channel   | dir | handshake                     | payload
//  ----------+-----+-------------------------------+------------------------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata: character, confidence; tuser:
//            |     |                               | has_char; tlast: end_of_text
//  m_axis    | out | m_axis_tvalid / m_axis_tready | tdata: ok, value_centi, status, reason,
//            |     |                               | confidence_echo
//  cfg       | in  | cfg_we (no wait)              | cfg_index, cfg_data
//
//  one request per cycle is accepted; the parse state updates on the edge that takes it
//  an end-marked request is snapshotted into the finish stage, checked there combinationally
//  and moves into the output register once that register is free
//  the critical path is the whole*100 + fraction add and the range compares in the finish stage
//  rst_n clears parse state, pipeline valids and the config registers to their defaults
//  a stalled output holds the finish stage, and only then does s_axis_tready drop
module decimal_text_to_centi_value_unit
    import dtcv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [7:0] character, [14:8] confidence, [15] zero
    input  logic        s_axis_tuser,  // [0] has_char
    input  logic        s_axis_tlast,  // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [0] ok, [16:1] value_centi, [18:17] status,
                                       // [22:19] reason, [29:23] confidence_echo, [31:30] zero
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // configuration registers
    logic [6:0]         min_conf_reg;
    logic signed [15:0] pmin_reg;
    logic signed [15:0] pmax_reg;

    // parse state
    parse_t parse_reg;
    parse_t parse_next;

    // finish stage: snapshot of the parse state after the end request
    logic       fin_valid_reg;
    parse_t     fin_parse_reg;
    logic [6:0] fin_conf_reg;

    // output register
    logic        out_valid_reg;
    logic        out_ok_reg;
    logic [15:0] out_value_reg;
    status_t     out_status_reg;
    reason_t     out_reason_reg;
    logic [6:0]  out_conf_reg;

    logic       in_take;
    logic       out_free;
    logic       fin_move;
    logic [7:0] in_char;
    logic [6:0] in_conf;
    logic [3:0] digit;
    logic [12:0] whole_calc;

    // finish stage results
    logic        res_ok;
    logic [15:0] res_value;
    status_t     res_status;
    reason_t     res_reason;
    logic [6:0]  frac_scaled;
    logic [15:0] mag;
    logic [15:0] mag_limit;
    logic signed [16:0] signed_val;

    assign in_char  = s_axis_tdata[7:0];
    assign in_conf  = s_axis_tdata[14:8];
    assign out_free = !out_valid_reg || m_axis_tready;
    assign fin_move = fin_valid_reg && out_free;
    // finish stage empties or moves on this cycle
    assign s_axis_tready = !fin_valid_reg || out_free;
    assign in_take  = s_axis_tvalid && s_axis_tready;

    assign digit      = 4'(in_char - CHAR_ZERO);
    assign whole_calc = {4'd0, parse_reg.whole_part} * 13'd10 + {9'd0, digit};

    // per-character parse step
    always_comb
    begin
        parse_next = parse_reg;
        if (s_axis_tuser)
        begin
            parse_next.at_start = 1'b0;
            if (parse_reg.latched_error == REASON_NONE)
            begin
                priority if (parse_reg.at_start && in_char == CHAR_MINUS)
                begin
                    parse_next.negative = 1'b1;
                end
                else if (in_char == CHAR_POINT)
                begin
                    if (parse_reg.seen_point)
                        parse_next.latched_error = REASON_DUP_POINT;
                    else
                        parse_next.seen_point = 1'b1;
                end
                else if (in_char < CHAR_ZERO || in_char > CHAR_NINE)
                begin
                    parse_next.latched_error = REASON_BAD_CHAR;
                end
                else
                begin
                    parse_next.digit_found = 1'b1;
                    if (parse_reg.seen_point)
                    begin
                        if (parse_reg.fraction_digits >= 2'd2)
                            parse_next.latched_error = REASON_TOO_MANY;
                        else
                        begin
                            // at most one digit stored before, so this stays below 100
                            parse_next.fraction_part = 7'(parse_reg.fraction_part * 7'd10)
                                                       + {3'd0, digit};
                            parse_next.fraction_digits = parse_reg.fraction_digits + 2'd1;
                        end
                    end
                    else if (whole_calc > {4'd0, WHOLE_MAX})
                    begin
                        parse_next.whole_part     = WHOLE_MAX;
                        parse_next.whole_overflow = 1'b1;
                    end
                    else
                    begin
                        parse_next.whole_part = whole_calc[8:0];
                    end
                end
            end
        end
    end

    // result checks in priority order
    always_comb
    begin
        unique case (fin_parse_reg.fraction_digits)
            2'd0:    frac_scaled = 7'd0;
            2'd1:    frac_scaled = 7'(fin_parse_reg.fraction_part * 7'd10);
            default: frac_scaled = fin_parse_reg.fraction_part;
        endcase
        mag        = 16'(fin_parse_reg.whole_part * 16'd100) + {9'd0, frac_scaled};
        mag_limit  = fin_parse_reg.negative ? MAG_MAX_NEG : MAG_MAX_POS;
        signed_val = fin_parse_reg.negative ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

        res_status = STATUS_OK;
        res_reason = REASON_NONE;
        priority if (fin_parse_reg.at_start)
        begin
            res_status = STATUS_RECOG;
            res_reason = REASON_EMPTY;
        end
        else if (fin_conf_reg < min_conf_reg)
        begin
            res_status = STATUS_LOW_CONF;
            res_reason = REASON_LOW_CONF;
        end
        else if (fin_parse_reg.latched_error != REASON_NONE)
        begin
            res_status = STATUS_RECOG;
            res_reason = fin_parse_reg.latched_error;
        end
        else if (!fin_parse_reg.digit_found)
        begin
            res_status = STATUS_RECOG;
            res_reason = REASON_NO_DIGITS;
        end
        else if (fin_parse_reg.whole_overflow || mag > mag_limit)
        begin
            res_status = STATUS_RANGE;
            res_reason = REASON_OVERFLOW;
        end
        else if (signed_val < 17'(pmin_reg) || signed_val > 17'(pmax_reg))
        begin
            res_status = STATUS_RANGE;
            res_reason = REASON_IMPLAUSIBLE;
        end
        res_ok    = (res_status == STATUS_OK);
        res_value = res_ok ? signed_val[15:0] : 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_conf_reg   <= MIN_CONF_RESET;
            pmin_reg       <= PMIN_RESET;
            pmax_reg       <= PMAX_RESET;
            parse_reg      <= PARSE_CLEAR;
            fin_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MIN_CONFIDENCE: min_conf_reg <= cfg_data[6:0];
                    CFG_PLAUSIBLE_MIN:  pmin_reg     <= cfg_data;
                    CFG_PLAUSIBLE_MAX:  pmax_reg     <= cfg_data;
                    default:            ;
                endcase
            end

            // parse state clears once the text is handed to the finish stage
            if (in_take)
                parse_reg <= s_axis_tlast ? PARSE_CLEAR : parse_next;

            if (in_take && s_axis_tlast)
                fin_valid_reg <= 1'b1;
            else if (fin_move)
                fin_valid_reg <= 1'b0;

            if (fin_move)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take && s_axis_tlast)
        begin
            fin_parse_reg <= parse_next;
            fin_conf_reg  <= in_conf;
        end
        if (fin_move)
        begin
            out_ok_reg     <= res_ok;
            out_value_reg  <= res_value;
            out_status_reg <= res_status;
            out_reason_reg <= res_reason;
            out_conf_reg   <= fin_conf_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_conf_reg, out_reason_reg, out_status_reg,
                            out_value_reg, out_ok_reg};

    // ok matches a clean status and a failed result carries zero
    a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_ok_reg == (out_status_reg == STATUS_OK)))
        else $error("ok flag disagrees with status");

    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ok_reg) |-> (out_value_reg == 16'd0))
        else $error("failed result carries a value");

    a_reason_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_reason_reg == REASON_NONE) == (out_status_reg == STATUS_OK)))
        else $error("reason and status disagree");

    // an end request leaves the parser cleared for the next text
    a_parse_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && s_axis_tlast) |=> parse_reg.at_start)
        else $error("parse state not cleared after end of text");

    // stalled finish stage keeps the input side closed
    a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_valid_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("request taken while finish stage is blocked");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: self-checking bench for decimal_text_to_centi_value_unit, text streamed per byte
// depends on dtcv_pkg and the unit; predicts every reading and checks it field by field
module tb_top;
    import dtcv_pkg::*;

    // total requests to send, idle requests included, gaps not counted
    localparam int ITEM_GOAL = 1650;
    // settle after the last reading has left before touching config
    localparam int SETTLE_CYCLES = 4;
    // long receiver hold-off used to back the unit up into its input
    localparam int HOLD_OFF_CYCLES = 80;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // parse progress of the text currently streaming in
    typedef struct packed {
        logic       fresh;       // no byte seen yet
        logic       neg;
        logic [8:0] whole;
        logic       whole_sat;   // sticky, whole part hit its ceiling
        logic [6:0] frac;
        logic [1:0] nfrac;
        logic       any_digit;
        logic       got_point;
        reason_t    err;         // first syntax error, later bytes ignored
    } text_state_t;

    // one reading as it leaves the unit
    typedef struct packed {
        logic               ok;
        logic signed [15:0] value;
        status_t            status;
        reason_t            reason;
        logic [6:0]         conf;
    } reading_t;

    localparam text_state_t TEXT_CLEAR = '{
        fresh:     1'b1,
        neg:       1'b0,
        whole:     9'd0,
        whole_sat: 1'b0,
        frac:      7'd0,
        nfrac:     2'd0,
        any_digit: 1'b0,
        got_point: 1'b0,
        err:       REASON_NONE
    };

    // our copy of the unit's registers and parse state
    logic [6:0]  lim_conf;
    int          lim_lo;
    int          lim_hi;
    text_state_t txt;

    reading_t readings_due[$];

    logic in_fire;          // request taken at the last rising edge
    logic tx_gaps;          // sender idles between bursts
    logic rx_stalls;        // receiver stalls on its own pattern
    int   burst_left;
    int   hold_req;         // receiver hold-off asked by a test, in cycles
    int   sent_items;
    int   text_count;
    int   readings_seen;
    int   readings_ok;
    int   fail_count;

    decimal_text_to_centi_value_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // generous ceiling, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("timeout: %0d readings still due", readings_due.size());
        $display("tb_top NOT OK");
        $finish;
    end

    // ---------------------------------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------------------------------

    // fold one text byte into the running parse
    function automatic void take_byte(input logic [7:0] ch);
        logic        first;
        int unsigned w;
        first     = txt.fresh;
        txt.fresh = 1'b0;
        // once an error is latched the rest of the text is ignored
        if (txt.err != REASON_NONE)
            return;
        // a minus only counts as a sign when it is the very first byte
        if (first && ch == CHAR_MINUS)
        begin
            txt.neg = 1'b1;
            return;
        end
        if (ch == CHAR_POINT)
        begin
            if (txt.got_point)
                txt.err = REASON_DUP_POINT;
            else
                txt.got_point = 1'b1;
            return;
        end
        if (ch < CHAR_ZERO || ch > CHAR_NINE)
        begin
            txt.err = REASON_BAD_CHAR;
            return;
        end
        txt.any_digit = 1'b1;
        if (txt.got_point)
        begin
            if (txt.nfrac >= 2'd2)
            begin
                txt.err = REASON_TOO_MANY;
                return;
            end
            txt.frac  = 7'(txt.frac * 10 + (ch - CHAR_ZERO));
            txt.nfrac = txt.nfrac + 2'd1;
        end
        else
        begin
            w = txt.whole * 10 + (ch - CHAR_ZERO);
            // whole part saturates and remembers it
            if (w > WHOLE_MAX)
            begin
                w = WHOLE_MAX;
                txt.whole_sat = 1'b1;
            end
            txt.whole = 9'(w);
        end
    endfunction

    // verdict on the finished text, in the unit's check order
    function automatic reading_t finish_text(input logic [6:0] conf);
        reading_t    r;
        int unsigned frac;
        int unsigned mag;
        int          v;
        r.ok     = 1'b0;
        r.value  = 16'sd0;
        r.status = STATUS_OK;
        r.reason = REASON_NONE;
        r.conf   = conf;
        if (txt.fresh)
        begin
            r.status = STATUS_RECOG;
            r.reason = REASON_EMPTY;
        end
        else if (conf < lim_conf)
        begin
            r.status = STATUS_LOW_CONF;
            r.reason = REASON_LOW_CONF;
        end
        else if (txt.err != REASON_NONE)
        begin
            r.status = STATUS_RECOG;
            r.reason = txt.err;
        end
        else if (!txt.any_digit)
        begin
            r.status = STATUS_RECOG;
            r.reason = REASON_NO_DIGITS;
        end
        else
        begin
            // one fraction digit means tenths, none means no fraction at all
            if (txt.nfrac == 2'd2)
                frac = txt.frac;
            else if (txt.nfrac == 2'd1)
                frac = txt.frac * 10;
            else
                frac = 0;
            mag = txt.whole * 100 + frac;
            // negative side reaches one further than the positive side
            if (txt.whole_sat || mag > (txt.neg ? 32'd32768 : 32'd32767))
            begin
                r.status = STATUS_RANGE;
                r.reason = REASON_OVERFLOW;
            end
            else
            begin
                v = txt.neg ? -int'(mag) : int'(mag);
                // an inverted window rejects everything
                if (v < lim_lo || v > lim_hi)
                begin
                    r.status = STATUS_RANGE;
                    r.reason = REASON_IMPLAUSIBLE;
                end
                else
                begin
                    r.ok    = 1'b1;
                    r.value = v[15:0];
                end
            end
        end
        txt = TEXT_CLEAR;
        return r;
    endfunction

    // ---------------------------------------------------------------------------------------
    // monitor: checks outgoing readings, then predicts from the request taken at this edge
    // ---------------------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        reading_t want;
        reading_t got;
        in_fire <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.ok     = m_axis_tdata[0];
            got.value  = m_axis_tdata[16:1];
            got.status = status_t'(m_axis_tdata[18:17]);
            got.reason = reason_t'(m_axis_tdata[22:19]);
            got.conf   = m_axis_tdata[29:23];
            readings_seen++;
            if (got.ok)
                readings_ok++;
            if (readings_due.size() == 0)
            begin
                if (fail_count < 10)
                    $display("unexpected reading: tdata=%h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = readings_due.pop_front();
                if (got.ok !== want.ok || got.value !== want.value
                    || got.status !== want.status || got.reason !== want.reason
                    || got.conf !== want.conf)
                begin
                    if (fail_count < 10)
                        $display({"reading mismatch: expected ok=%0b value=%0d status=%0d ",
                                  "reason=%0d conf=%0d, got ok=%0b value=%0d status=%0d ",
                                  "reason=%0d conf=%0d"},
                                 want.ok, $signed(want.value), want.status, want.reason,
                                 want.conf, got.ok, $signed(got.value), got.status,
                                 got.reason, got.conf);
                    fail_count++;
                end
            end
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            if (s_axis_tuser)
                take_byte(s_axis_tdata[7:0]);
            if (s_axis_tlast)
                readings_due.push_back(finish_text(s_axis_tdata[14:8]));
        end
    end

    // ---------------------------------------------------------------------------------------
    // receiver: ready changes on the falling edge; a hold-off request wins over the pattern
    // ---------------------------------------------------------------------------------------
    initial
    begin : receiver
        int   hold_left;
        int   run_left;
        logic run_level;
        hold_left     = 0;
        run_left      = 0;
        run_level     = 1'b1;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0)
            begin
                m_axis_tready = 1'b0;
                hold_left--;
            end
            else if (!rx_stalls)
                m_axis_tready = 1'b1;
            else
            begin
                // runs of ready and stall of random length, mostly ready
                if (run_left == 0)
                begin
                    run_level = ($urandom_range(0, 2) != 0);
                    run_left  = $urandom_range(1, 8);
                end
                m_axis_tready = run_level;
                run_left--;
            end
        end
    end

    // ---------------------------------------------------------------------------------------
    // shared drivers
    // ---------------------------------------------------------------------------------------

    // offer one request and wait until the unit takes it; valid stays up for the next one
    task automatic send_req(input logic [7:0] ch, input logic hc, input logic eot,
                            input logic [6:0] conf);
        if (tx_gaps)
        begin
            if (burst_left == 0)
            begin
                s_axis_tvalid = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {1'b0, conf, ch};
        s_axis_tuser  = hc;
        s_axis_tlast  = eot;
        do
            @(negedge clk);
        while (!in_fire);
        sent_items++;
    endtask

    // whole text from a string, ending either on its last byte or on a bare end request
    task automatic send_string(input string s, input logic [6:0] conf, input logic bare_end);
        int i;
        for (i = 0; i < s.len(); i++)
            send_req(s[i], 1'b1, (i == s.len() - 1) && !bare_end, conf);
        if (bare_end || s.len() == 0)
            send_req(8'h00, 1'b0, 1'b1, conf);
        text_count++;
    endtask

    // let every pending reading drain before the config changes
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (readings_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_MIN_CONFIDENCE: lim_conf = val[6:0];
            CFG_PLAUSIBLE_MIN:  lim_lo   = int'($signed(val));
            CFG_PLAUSIBLE_MAX:  lim_hi   = int'($signed(val));
            default: ;
        endcase
    endtask

    task automatic set_limits(input int conf, input int lo, input int hi);
        drain();
        write_reg(CFG_MIN_CONFIDENCE, 16'(conf));
        write_reg(CFG_PLAUSIBLE_MIN, 16'(lo));
        write_reg(CFG_PLAUSIBLE_MAX, 16'(hi));
    endtask

    // one random text: mostly well formed with random content, some broken, a few empty
    task automatic send_random_text();
        logic [7:0]  chars[$];
        int unsigned pick;
        int unsigned mode;
        int unsigned whole_val;
        int unsigned start;
        int unsigned nfrac;
        int unsigned i;
        logic        bare_end;
        logic        last;
        logic [6:0]  conf;
        pick = $urandom_range(0, 99);
        if (pick >= 3)
        begin
            if ($urandom_range(0, 3) == 0)
                chars.push_back(CHAR_MINUS);
            mode = $urandom_range(0, 9);
            if (mode != 0)
            begin
                if (mode <= 5)
                    whole_val = $urandom_range(0, 99);
                else if (mode <= 7)
                    whole_val = $urandom_range(100, 511);
                else if (mode == 8)
                    whole_val = $urandom_range(320, 330);   // around the 16-bit edge
                else
                    whole_val = $urandom_range(512, 99999); // saturates the whole part
                if ($urandom_range(0, 7) == 0)
                    chars.push_back(CHAR_ZERO);
                start = chars.size();
                do
                begin
                    chars.insert(start, 8'(CHAR_ZERO + whole_val % 10));
                    whole_val = whole_val / 10;
                end
                while (whole_val != 0);
            end
            if ($urandom_range(0, 2) != 0)
            begin
                chars.push_back(CHAR_POINT);
                nfrac = $urandom_range(0, 2);
                repeat (nfrac) chars.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
            end
            // broken texts
            if (pick < 20)
            begin
                case ($urandom_range(0, 3))
                    0: chars.insert($urandom_range(0, chars.size()), 8'($urandom_range(0, 255)));
                    1:
                    begin
                        chars.push_back(CHAR_POINT);
                        repeat (3) chars.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
                    end
                    2: chars.insert($urandom_range(1, chars.size() + 1) - 1, CHAR_MINUS);
                    default:
                    begin
                        // bytes right next to the digits and the sign
                        case ($urandom_range(0, 3))
                            0: chars.insert($urandom_range(0, chars.size()), 8'h2f);
                            1: chars.insert($urandom_range(0, chars.size()), 8'h3a);
                            2: chars.insert($urandom_range(0, chars.size()), 8'h2c);
                            default: chars.insert($urandom_range(0, chars.size()), CHAR_POINT);
                        endcase
                    end
                endcase
            end
        end
        case ($urandom_range(0, 19))
            0, 1, 2: conf = 7'($urandom_range(0, 100));
            3:       conf = 7'($urandom_range(101, 127));
            default: conf = 7'($urandom_range(lim_conf, 100));
        endcase
        bare_end = (chars.size() == 0) || ($urandom_range(0, 3) == 0);
        for (i = 0; i < chars.size(); i++)
        begin
            // idle requests sprinkled in, their byte and confidence must be ignored
            if ($urandom_range(0, 9) == 0)
                send_req(8'($urandom_range(0, 255)), 1'b0, 1'b0, 7'($urandom_range(0, 127)));
            last = (i == chars.size() - 1) && !bare_end;
            send_req(chars[i], 1'b1, last, last ? conf : 7'($urandom_range(0, 127)));
        end
        if (bare_end)
            send_req(8'($urandom_range(0, 255)), 1'b0, 1'b1, conf);
        text_count++;
    endtask

    // ---------------------------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------------------------

    // every reason and the corner cases at reset config (60, -40.00 .. 125.00)
    task automatic test_directed();
        send_string("", 7'd80, 1'b1);          // empty text
        send_string("-", 7'd80, 1'b0);         // sign only, no digits
        send_string("5", 7'd0, 1'b0);          // confidence too low
        send_string("..", 7'd80, 1'b0);        // second point
        send_req(8'hff, 1'b1, 1'b0, 7'd90);    // bad byte latched, next byte ignored
        send_req(8'h00, 1'b1, 1'b1, 7'd90);
        text_count++;
        send_string("1-", 7'd80, 1'b0);        // minus after the first byte
        send_string(".123", 7'd80, 1'b0);      // third fraction digit
        send_string("-0", 7'd80, 1'b0);        // minus zero reads as 0
        send_string("999", 7'd80, 1'b0);       // whole part saturates
        send_string("200", 7'd80, 1'b0);       // above plausible max
        send_string("5", 7'd127, 1'b0);        // confidence over 100 passes and echoes
        send_string("-12.3", 7'd100, 1'b0);    // single fraction digit is tenths
        // byte, idle request, then a bare end exactly at the threshold
        send_req(8'h37, 1'b1, 1'b0, 7'd0);
        send_req(8'h41, 1'b0, 1'b0, 7'd3);
        send_req(8'h00, 1'b0, 1'b1, 7'd60);
        text_count++;
    endtask

    // plausible bounds at their extremes, confidence threshold at 0 and 100, overflow bounds, inverted window
    task automatic test_config();
        set_limits(0, -32768, 32767);
        send_string("-327.68", 7'd0, 1'b0);    // most negative value fits
        send_string("-327.69", 7'd0, 1'b0);    // one past it overflows
        send_string("327.67", 7'd5, 1'b1);
        send_string("327.68", 7'd5, 1'b0);
        set_limits(100, 100, -100);
        send_string("0", 7'd100, 1'b0);        // inverted window, nothing plausible
        send_string("1", 7'd99, 1'b0);
        set_limits(50, 0, 0);
        send_string("0.00", 7'd50, 1'b0);
        send_string("-0", 7'd50, 1'b1);
        send_string("0.01", 7'd50, 1'b0);
    endtask

    // receiver holds off while the sender keeps offering, so the input has to stall
    task automatic test_backpressure();
        int n;
        set_limits(MIN_CONF_RESET, PMIN_RESET, PMAX_RESET);
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        hold_req  = HOLD_OFF_CYCLES;
        for (n = 0; n < 12; n++)
            send_random_text();
        drain();
    endtask

    // random texts over several config settings, idling on and off
    task automatic test_random();
        int phase;
        int base;
        int goal;
        int a;
        int b;
        base = sent_items;
        goal = ITEM_GOAL - sent_items;
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: set_limits(MIN_CONF_RESET, PMIN_RESET, PMAX_RESET);
                1: set_limits(0, -32768, 32767);
                2: set_limits($urandom_range(0, 100), -int'($urandom_range(0, 32768)),
                              int'($urandom_range(0, 32767)));
                3: set_limits(100, -32768, 32767);
                default:
                begin
                    // any two 16-bit bounds, sometimes inverted
                    a = int'($signed(16'($urandom_range(0, 65535))));
                    b = int'($signed(16'($urandom_range(0, 65535))));
                    if ($urandom_range(0, 2) != 0 && a > b)
                        set_limits($urandom_range(0, 100), b, a);
                    else
                        set_limits($urandom_range(0, 100), a, b);
                end
            endcase
            // one phase runs flat out on both sides
            tx_gaps   = (phase != 4);
            rx_stalls = (phase != 4);
            while (sent_items < base + (goal * (phase + 1)) / 6)
                send_random_text();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 16'h0000;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_MIN_CONFIDENCE;
        cfg_data      = 16'h0000;
        lim_conf      = MIN_CONF_RESET;
        lim_lo        = int'(PMIN_RESET);
        lim_hi        = int'(PMAX_RESET);
        txt           = TEXT_CLEAR;
        tx_gaps       = 1'b1;
        rx_stalls     = 1'b1;
        burst_left    = 0;
        hold_req      = 0;
        sent_items    = 0;
        text_count    = 0;
        readings_seen = 0;
        readings_ok   = 0;
        fail_count    = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_config();
        test_backpressure();
        test_random();

        // everything sent; wait out the remaining readings and the pipeline
        drain();
        repeat (8) @(negedge clk);
        fail_count += readings_due.size();

        $display("run covered %0d texts in %0d requests, all registers at several settings",
                 text_count, sent_items);
        $display("%0d readings checked, %0d of them accepted values, %0d failures",
                 readings_seen, readings_ok, fail_count);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
